@@ sv/rate_limited_priority_sender_assert.svh @@
// Assertion macros for the checker file.
`ifndef RATE_LIMITED_PRIORITY_SENDER_ASSERT_SVH
`define RATE_LIMITED_PRIORITY_SENDER_ASSERT_SVH

// Clocked assertion that is switched off while reset is asserted.
`define RLPS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define RLPS_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/rlps_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rlps_pkg;

	localparam int DEF_CHANNELS          = 4;
	localparam int DEF_CLEANUP_PERIOD_MS = 2000;

	localparam int SLOTS    = 4;
	localparam int CHART_CH = 2;

	localparam logic [15:0] RST_INTERVAL_STATE   = 16'd800;
	localparam logic [15:0] RST_INTERVAL_METRICS = 16'd1500;
	localparam logic [15:0] RST_INTERVAL_CHART   = 16'd1200;
	localparam logic [15:0] RST_INTERVAL_SUMMARY = 16'd1500;
	localparam logic [7:0]  RST_PRIORITY_ORDER   = 8'd228;
	localparam logic [15:0] RST_LARGE_CHART      = 16'd3500;
	localparam logic [7:0]  RST_SLOW_FACTOR      = 8'd2;
	localparam logic [7:0]  ZERO_FACTOR_AS       = 8'd2;

	typedef enum logic [2:0] {
		REG_INTERVAL_STATE   = 3'd0,
		REG_INTERVAL_METRICS = 3'd1,
		REG_INTERVAL_CHART   = 3'd2,
		REG_INTERVAL_SUMMARY = 3'd3,
		REG_PRIORITY_ORDER   = 3'd4,
		REG_LARGE_CHART      = 3'd5,
		REG_SLOW_FACTOR      = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [3:0][15:0] interval_ms;
		logic [7:0]       priority_order;
		logic [15:0]      large_chart_bytes;
		logic [7:0]       chart_slow_factor;
	} cfg_t;

	typedef struct packed {
		logic [31:0] now_ms;
		logic        dirty_state;
		logic        dirty_metrics;
		logic        dirty_chart;
		logic        dirty_summary;
		logic [15:0] chart_payload_bytes;
	} tick_t;

	typedef struct packed {
		logic       send_valid;
		logic [1:0] send_channel;
		logic       cleanup_pulse;
		logic [3:0] pending_left;
	} result_t;

endpackage

`default_nettype wire

@@ sv/rlps_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rlps_cfg_regs (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_wr_en,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [15:0]  cfg_wdata,
	output rlps_pkg::cfg_t    cfg
);
	import rlps_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.interval_ms[0]    <= RST_INTERVAL_STATE;
			cfg_q.interval_ms[1]    <= RST_INTERVAL_METRICS;
			cfg_q.interval_ms[2]    <= RST_INTERVAL_CHART;
			cfg_q.interval_ms[3]    <= RST_INTERVAL_SUMMARY;
			cfg_q.priority_order    <= RST_PRIORITY_ORDER;
			cfg_q.large_chart_bytes <= RST_LARGE_CHART;
			cfg_q.chart_slow_factor <= RST_SLOW_FACTOR;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_INTERVAL_STATE:   cfg_q.interval_ms[0]    <= cfg_wdata;
				REG_INTERVAL_METRICS: cfg_q.interval_ms[1]    <= cfg_wdata;
				REG_INTERVAL_CHART:   cfg_q.interval_ms[2]    <= cfg_wdata;
				REG_INTERVAL_SUMMARY: cfg_q.interval_ms[3]    <= cfg_wdata;
				REG_PRIORITY_ORDER:   cfg_q.priority_order    <= cfg_wdata[7:0];
				REG_LARGE_CHART:      cfg_q.large_chart_bytes <= cfg_wdata;
				REG_SLOW_FACTOR:      cfg_q.chart_slow_factor <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ sv/rlps_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rlps_core #(
	parameter int CHANNELS          = rlps_pkg::DEF_CHANNELS,
	parameter int CLEANUP_PERIOD_MS = rlps_pkg::DEF_CLEANUP_PERIOD_MS
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         advance,
	input  wire rlps_pkg::tick_t tick,
	input  wire rlps_pkg::cfg_t  cfg,
	output rlps_pkg::result_t res
);
	import rlps_pkg::*;

	// Only four channels can be named by a priority slot or carry a dirty bit.
	localparam int ACTIVE = (CHANNELS < 4) ? CHANNELS : 4;
	localparam logic [31:0] PERIOD = 32'(CLEANUP_PERIOD_MS);

	logic [31:0]       last_send_q [ACTIVE];
	logic [ACTIVE-1:0] pending_q;
	logic [31:0]       last_cleanup_q;
	logic [15:0]       chart_seen_q;

	logic [7:0]  factor;
	logic [23:0] chart_prod;
	logic [15:0] chart_itv;
	logic [3:0]  dirty4;
	wire  [3:0]  pend4;
	wire  [3:0]  elig4;
	logic [3:0]  gnt4;
	logic [3:0]  pend_next4;
	logic        found;
	logic [1:0]  sel;
	logic [1:0]  slot_ch;
	logic        cleanup;

	assign factor     = (cfg.chart_slow_factor == '0) ? ZERO_FACTOR_AS : cfg.chart_slow_factor;
	assign chart_prod = cfg.interval_ms[CHART_CH] * factor;
	assign chart_itv  = (chart_seen_q >= cfg.large_chart_bytes) ? chart_prod[15:0]
		: cfg.interval_ms[CHART_CH];

	assign dirty4 = {tick.dirty_summary, tick.dirty_chart, tick.dirty_metrics, tick.dirty_state};

	for (genvar i = 0; i < 4; i++) begin : g_ch
		if (i < ACTIVE) begin : g_on
			logic [31:0] age;
			logic [15:0] itv;
			assign age      = tick.now_ms - last_send_q[i];
			assign itv      = (i == CHART_CH) ? chart_itv : cfg.interval_ms[i];
			assign pend4[i] = pending_q[i] | dirty4[i];
			assign elig4[i] = pend4[i] && (age >= {16'd0, itv});
		end else begin : g_off
			assign pend4[i] = 1'b0;
			assign elig4[i] = 1'b0;
		end
	end

	always_comb begin
		found   = 1'b0;
		sel     = '0;
		slot_ch = '0;
		for (int s = 0; s < SLOTS; s++) begin
			slot_ch = cfg.priority_order[2*s +: 2];
			if (!found && elig4[slot_ch]) begin
				found = 1'b1;
				sel   = slot_ch;
			end
		end
		gnt4       = found ? (4'b0001 << sel) : 4'b0000;
		pend_next4 = pend4 & ~gnt4;
	end

	assign cleanup = (tick.now_ms - last_cleanup_q) >= PERIOD;

	assign res.send_valid    = found;
	assign res.send_channel  = sel;
	assign res.cleanup_pulse = cleanup;
	assign res.pending_left  = pend_next4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ACTIVE; i++) begin
				last_send_q[i] <= '0;
			end
			pending_q      <= '0;
			last_cleanup_q <= '0;
			chart_seen_q   <= '0;
		end else if (advance) begin
			for (int i = 0; i < ACTIVE; i++) begin
				if (gnt4[i]) begin
					last_send_q[i] <= tick.now_ms;
				end
			end
			pending_q <= pend_next4[ACTIVE-1:0];
			if (gnt4[CHART_CH]) begin
				chart_seen_q <= tick.chart_payload_bytes;
			end
			if (cleanup) begin
				last_cleanup_q <= tick.now_ms;
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/rate_limited_priority_sender.sv @@
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_ready  in_data (tick_t)
// out      output     out_valid/ out_ready out_data (result_t)
// cfg      input      cfg_wr_en            cfg_index, cfg_wdata
//
// One tick can be accepted every cycle while the output is not stalled; its result is then registered in out_q.
// The rate is set by the single decision stage, whose state is written back on each advance.
// Reset is asynchronous and active low; it restores the register defaults and clears the valid flags and core state.
// A stalled output holds its beat while the input register can still take one more tick if it is empty.
`timescale 1ns / 1ps
`default_nettype none

module rate_limited_priority_sender #(
	parameter int CHANNELS          = rlps_pkg::DEF_CHANNELS,
	parameter int CLEANUP_PERIOD_MS = rlps_pkg::DEF_CLEANUP_PERIOD_MS
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire rlps_pkg::tick_t in_data,
	output logic              out_valid,
	input  wire logic         out_ready,
	output rlps_pkg::result_t out_data,
	input  wire logic         cfg_wr_en,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [15:0]  cfg_wdata
);
	import rlps_pkg::*;

	cfg_t    cfg;
	tick_t   tick_s1;
	logic    valid_s1;
	result_t res;
	result_t out_q;
	logic    out_valid_q;
	logic    advance;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	rlps_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	rlps_core #(
		.CHANNELS          (CHANNELS),
		.CLEANUP_PERIOD_MS (CLEANUP_PERIOD_MS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.tick    (tick_s1),
		.cfg     (cfg),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (in_valid && in_ready) || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			tick_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

@@ sv/rlps_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "rate_limited_priority_sender_assert.svh"

module rlps_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         in_valid,
	input wire logic         in_ready,
	input wire logic         out_valid,
	input wire logic         out_ready,
	input wire rlps_pkg::result_t out_data
);
	import rlps_pkg::*;

	`RLPS_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "output beat changed while stalled")
	`RLPS_ASSERT(a_idle_channel, clk, arst_n, out_valid && !out_data.send_valid |-> out_data.send_channel == 2'd0, "channel set without a grant")
	`RLPS_ASSERT(a_grant_clears, clk, arst_n, out_valid && out_data.send_valid |-> !out_data.pending_left[out_data.send_channel], "granted channel still pending")
	`RLPS_ASSERT_ALWAYS(a_input_stall, clk, in_valid && !in_ready |-> out_valid && !out_ready, "input stalled without an output stall")

endmodule

bind rate_limited_priority_sender rlps_checker u_rlps_checker (.*);

`default_nettype wire
